/* hdl/stpq_pkg.sv */
// ----------------------------------------------------------------------------
// stpq_pkg
// Types and codes shared by the sorted-list priority queue cells and top level.
// ----------------------------------------------------------------------------
package stpq_pkg;

    localparam int PRIO_W   = 8;
    localparam int HANDLE_W = 8;
    localparam int OCC_W    = 5;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic                valid;
        logic [PRIO_W-1:0]   prio;
        logic [HANDLE_W-1:0] handle;
    } slot_t;

    typedef struct packed {
        logic                insert;
        logic                remove;
        logic                fifo_mode;
        logic [PRIO_W-1:0]   prio;
        logic [HANDLE_W-1:0] handle;
    } cmd_t;

endpackage

/* hdl/stable_priority_queue_top.sv */
// ----------------------------------------------------------------------------
// stable_priority_queue_top
// Bounded ready queue kept sorted in a row of slot cells; stable priority
// insert or FIFO append, remove from head, one registered result per command.
// ----------------------------------------------------------------------------
//  channel  | signals                                          | role
//  s_       | s_valid s_ready s_opcode s_in_priority s_in_handle | command in
//  m_       | m_valid m_ready m_status m_out_priority m_out_handle m_occupancy | result out
//  cfg_     | cfg_wr_en cfg_wr_data                            | fifo_mode write
//
//  one command per cycle while s_ready is high; every slot compares and shifts in the same cycle
//  the insert position ripples through the cell row, DEPTH cells long
//  result appears in the cycle after the transaction, held while m_ready is low
//  a new command is taken while the result register empties in that cycle
//  reset clears slot valid flags, count, fifo_mode and the result valid flag
// ----------------------------------------------------------------------------
module stable_priority_queue_top #(
    parameter int DEPTH = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_opcode,
    input  logic [7:0] s_in_priority,
    input  logic [7:0] s_in_handle,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_status,
    output logic [7:0] m_out_priority,
    output logic [7:0] m_out_handle,
    output logic [4:0] m_occupancy
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                       fifo_mode_reg;
    logic [CNT_W-1:0]           count_reg;
    logic [CNT_W-1:0]           count_next;
    logic                       out_valid_reg;
    stpq_pkg::status_t          status_reg;
    stpq_pkg::status_t          status_next;
    logic [stpq_pkg::PRIO_W-1:0]   out_prio_reg;
    logic [stpq_pkg::PRIO_W-1:0]   out_prio_next;
    logic [stpq_pkg::HANDLE_W-1:0] out_handle_reg;
    logic [stpq_pkg::HANDLE_W-1:0] out_handle_next;
    logic [stpq_pkg::OCC_W-1:0]    occ_reg;

    logic            take;
    logic            full;
    logic            empty;
    stpq_pkg::cmd_t  cmd;
    stpq_pkg::slot_t slots [DEPTH];
    stpq_pkg::slot_t lefts [DEPTH];
    stpq_pkg::slot_t rights[DEPTH];
    logic            seen  [DEPTH+1];

    assign s_ready = !out_valid_reg || m_ready;
    assign take    = s_valid && s_ready;
    assign full    = slots[DEPTH-1].valid;
    assign empty   = !slots[0].valid;

    always_comb begin
        cmd.insert    = take && (s_opcode == stpq_pkg::OP_INSERT) && !full;
        cmd.remove    = take && (s_opcode == stpq_pkg::OP_REMOVE) && !empty;
        cmd.fifo_mode = fifo_mode_reg;
        cmd.prio      = s_in_priority;
        cmd.handle    = s_in_handle;
    end

    assign seen[0] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            if (gi == 0) begin : g_head
                always_comb begin
                    lefts[gi]       = slots[gi];
                    lefts[gi].valid = 1'b1;
                end
            end else begin : g_mid
                assign lefts[gi] = slots[gi-1];
            end
            if (gi == DEPTH - 1) begin : g_tail
                always_comb begin
                    rights[gi]       = slots[gi];
                    rights[gi].valid = 1'b0;
                end
            end else begin : g_body
                assign rights[gi] = slots[gi+1];
            end
            stpq_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .cmd      (cmd),
                .left     (lefts[gi]),
                .seen_in  (seen[gi]),
                .right    (rights[gi]),
                .slot     (slots[gi]),
                .seen_out (seen[gi+1])
            );
        end
    endgenerate

    always_comb begin
        count_next      = count_reg;
        status_next     = stpq_pkg::ST_OK;
        out_prio_next   = '0;
        out_handle_next = '0;
        if (s_opcode == stpq_pkg::OP_INSERT) begin
            if (full) begin
                status_next = stpq_pkg::ST_FULL;
            end else begin
                count_next = count_reg + CNT_W'(1);
            end
        end else begin
            if (empty) begin
                status_next = stpq_pkg::ST_EMPTY;
            end else begin
                count_next      = count_reg - CNT_W'(1);
                out_prio_next   = slots[0].prio;
                out_handle_next = slots[0].handle;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fifo_mode_reg <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                fifo_mode_reg <= cfg_wr_data;
            end
            if (take) begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (take) begin
            status_reg     <= status_next;
            out_prio_reg   <= out_prio_next;
            out_handle_reg <= out_handle_next;
            occ_reg        <= stpq_pkg::OCC_W'(count_next);
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_status       = status_reg;
    assign m_out_priority = out_prio_reg;
    assign m_out_handle   = out_handle_reg;
    assign m_occupancy    = occ_reg;

endmodule

/* hdl/stpq_cell.sv */
// ----------------------------------------------------------------------------
// stpq_cell
// One queue slot: holds an entry, shifts toward the tail on insert and toward
// the head on remove, and passes the insert-position flag to the next slot.
// ----------------------------------------------------------------------------
module stpq_cell (
    input  logic           aclk,
    input  logic           aresetn,
    input  stpq_pkg::cmd_t cmd,
    input  stpq_pkg::slot_t left,
    input  logic           seen_in,
    input  stpq_pkg::slot_t right,
    output stpq_pkg::slot_t slot,
    output logic           seen_out
);

    stpq_pkg::slot_t slot_reg;
    stpq_pkg::slot_t slot_next;
    logic            hit;

    assign hit      = slot_reg.valid && !cmd.fifo_mode && (slot_reg.prio > cmd.prio);
    assign seen_out = seen_in | hit;
    assign slot     = slot_reg;

    always_comb begin
        slot_next = slot_reg;
        if (cmd.insert) begin
            if (seen_in) begin
                slot_next = left;
            end else if (hit || (!slot_reg.valid && left.valid)) begin
                slot_next.valid  = 1'b1;
                slot_next.prio   = cmd.prio;
                slot_next.handle = cmd.handle;
            end
        end else if (cmd.remove) begin
            slot_next = right;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg.valid <= 1'b0;
        end else begin
            slot_reg <= slot_next;
        end
    end

endmodule

/* hdl/stpq_checker.sv */
// ----------------------------------------------------------------------------
// stpq_checker
// Port-level checks for the priority queue result channel, bound to the top.
// ----------------------------------------------------------------------------
module stpq_checker #(
    parameter int DEPTH = 16
) (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [1:0] m_status,
    input logic [7:0] m_out_priority,
    input logic [7:0] m_out_handle,
    input logic [4:0] m_occupancy
);

    // stalled result transaction holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_out_priority)
            && $stable(m_out_handle) && $stable(m_occupancy))
        else $error("stalled result changed");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == stpq_pkg::ST_OK) || (m_status == stpq_pkg::ST_EMPTY)
            || (m_status == stpq_pkg::ST_FULL))
        else $error("undefined status code");

    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == stpq_pkg::ST_EMPTY) |->
            (m_out_priority == 8'd0) && (m_out_handle == 8'd0) && (m_occupancy == 5'd0))
        else $error("remove on empty returned data or nonzero occupancy");

    a_full_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == stpq_pkg::ST_FULL) |->
            (m_out_priority == 8'd0) && (m_out_handle == 8'd0)
            && (m_occupancy == 5'(DEPTH)))
        else $error("dropped insert result inconsistent with full queue");

endmodule

bind stable_priority_queue_top stpq_checker #(.DEPTH(DEPTH)) u_stpq_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_status       (m_status),
    .m_out_priority (m_out_priority),
    .m_out_handle   (m_out_handle),
    .m_occupancy    (m_occupancy)
);
